@@ rtl/core/hbl_pkg.sv @@
// Shared types, character constants and the hex digit decoder for the hex
// byte list parser. No dependencies.
`timescale 1ns / 1ps

package hbl_pkg;

  localparam logic [7:0] CHAR_END   = 8'h00;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CHAR_UC_A  = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UC_F  = 8'h46;  // 'F'
  localparam logic [7:0] CHAR_LC_A  = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LC_F  = 8'h66;  // 'f'
  localparam logic [7:0] DIGIT_TEN  = 8'd10;
  localparam logic [4:0] HEX_NONE   = 5'd16;
  localparam int unsigned NIBBLE_W  = 4;

  localparam logic [15:0] CAP_RESET = 16'hFFFF;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SEP_LOW   = 3'd0,
    REG_SEP_HIGH  = 3'd1,
    REG_BLANK_LOW = 3'd2,
    REG_BLANK_HIGH = 3'd3,
    REG_CAPACITY  = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DIGIT = 2'd1,
    ST_BAD_CHAR  = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic [63:0] sep_low;
    logic [63:0] sep_high;
    logic [63:0] blank_low;
    logic [63:0] blank_high;
    logic [15:0] capacity;
  } cfg_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  byte_value;
    logic        text_done;
    status_e     parse_status;
    logic [15:0] bytes_so_far;
  } result_t;

  // 0..15 for a hex digit, HEX_NONE otherwise
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      v = c - CHAR_ZERO;
      return v[4:0];
    end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
      v = c - CHAR_UC_A + DIGIT_TEN;
      return v[4:0];
    end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
      v = c - CHAR_LC_A + DIGIT_TEN;
      return v[4:0];
    end
    return HEX_NONE;
  endfunction

  // Map lookup: codes 128 and up are in no map
  function automatic logic in_map(input logic [63:0] lo, input logic [63:0] hi,
                                  input logic [7:0] c);
    if (c[7]) begin
      return 1'b0;
    end else if (c[6]) begin
      return hi[c[5:0]];
    end
    return lo[c[5:0]];
  endfunction

endpackage

@@ rtl/core/hex_byte_list_parser_top.sv @@
// Top level of the hex byte list parser: input register, parse step and
// result register. Depends on hbl_pkg, hbl_cfg_regs and hbl_parse_core.
// Each character is parsed from the input register into the result register.
// Throughput: one character per cycle; ready drops only while the result register
// holds a result that the sink does not take.
// Reset (rst_ni low, asynchronous): empty pipeline, parser expecting a high digit,
// count zero, maps cleared, capacity 65535.
`timescale 1ns / 1ps

module hex_byte_list_parser_top import hbl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // character stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_char
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] byte_value, [23:8] bytes_so_far
  output logic [2:0]  m_axis_tuser,   // [0] byte_valid, [2:1] parse_status
  output logic        m_axis_tlast    // text_done
);

  cfg_t    cfg;
  logic    in_valid_q;
  logic [7:0] in_char_q;
  logic    out_free, step;
  logic    res_valid;
  result_t res;
  logic    out_valid_q;
  result_t out_q;

  hbl_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
    end
  end

  hbl_parse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .char_i      (in_char_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Hold the result until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && step && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.bytes_so_far, out_q.byte_value};
  assign m_axis_tuser  = {out_q.parse_status, out_q.byte_valid};
  assign m_axis_tlast  = out_q.text_done;

endmodule

@@ rtl/core/hbl_cfg_regs.sv @@
// APB-style configuration registers of the hex byte list parser: character
// maps and byte capacity. Depends on hbl_pkg.
`timescale 1ns / 1ps

module hbl_cfg_regs import hbl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[5:3]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sep_low    <= '0;
      cfg_q.sep_high   <= '0;
      cfg_q.blank_low  <= '0;
      cfg_q.blank_high <= '0;
      cfg_q.capacity   <= CAP_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_SEP_LOW:    cfg_q.sep_low    <= pwdata;
        REG_SEP_HIGH:   cfg_q.sep_high   <= pwdata;
        REG_BLANK_LOW:  cfg_q.blank_low  <= pwdata;
        REG_BLANK_HIGH: cfg_q.blank_high <= pwdata;
        REG_CAPACITY:   cfg_q.capacity   <= pwdata[15:0];
        default: ;  // drop writes outside the register list
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SEP_LOW:    prdata = cfg_q.sep_low;
      REG_SEP_HIGH:   prdata = cfg_q.sep_high;
      REG_BLANK_LOW:  prdata = cfg_q.blank_low;
      REG_BLANK_HIGH: prdata = cfg_q.blank_high;
      REG_CAPACITY:   prdata = {48'd0, cfg_q.capacity};
      default:        prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/hbl_parse_core.sv @@
// Parser state and one-character step logic: classify the character, advance
// the phase and form at most one result. Depends on hbl_pkg.
`timescale 1ns / 1ps

module hbl_parse_core import hbl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] char_i,
  input  cfg_t       cfg_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  typedef enum logic [1:0] {
    PH_HIGH = 2'd0,
    PH_LOW  = 2'd1,
    PH_SEP  = 2'd2,
    PH_DROP = 2'd3
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  nib_q, nib_d;
  logic [15:0] count_q, count_d;

  logic        is_end, is_blank, is_sep;
  logic [4:0]  hex;
  logic        do_emit, emit_done, do_fail, do_finish;
  logic [7:0]  emit_val;
  phase_e      emit_next;
  status_e     fail_st;
  logic        full;
  logic [15:0] count_inc;

  assign is_end    = (char_i == CHAR_END);
  assign is_blank  = in_map(cfg_i.blank_low, cfg_i.blank_high, char_i);
  assign is_sep    = !is_blank && in_map(cfg_i.sep_low, cfg_i.sep_high, char_i);
  assign hex       = hex_value(char_i);
  assign full      = (count_q >= cfg_i.capacity);
  assign count_inc = count_q + 16'd1;

  // Decide what the character does
  always_comb begin
    do_emit   = 1'b0;
    emit_done = 1'b0;
    emit_val  = 8'd0;
    emit_next = PH_HIGH;
    do_fail   = 1'b0;
    fail_st   = ST_OK;
    do_finish = 1'b0;
    phase_d   = phase_q;
    nib_d     = nib_q;
    count_d   = count_q;
    unique case (phase_q)
      PH_HIGH: begin
        if (is_end) begin
          do_finish = 1'b1;
        end else if (is_blank) begin
          phase_d = PH_HIGH;
        end else if (is_sep) begin
          do_emit = 1'b1;
        end else if (hex[4]) begin
          do_fail = 1'b1;
          fail_st = ST_BAD_DIGIT;
        end else begin
          nib_d   = hex[3:0];
          phase_d = PH_LOW;
        end
      end
      PH_LOW: begin
        emit_val = {4'd0, nib_q};
        if (is_end) begin
          do_emit   = 1'b1;
          emit_done = 1'b1;
        end else if (is_blank) begin
          do_emit   = 1'b1;
          emit_next = PH_SEP;
        end else if (is_sep) begin
          do_emit = 1'b1;
        end else if (hex[4]) begin
          do_fail = 1'b1;
          fail_st = ST_BAD_DIGIT;
        end else begin
          do_emit   = 1'b1;
          emit_val  = {nib_q, hex[3:0]};
          emit_next = PH_SEP;
        end
      end
      PH_SEP: begin
        if (is_end) begin
          do_finish = 1'b1;
        end else if (is_blank) begin
          phase_d = PH_SEP;
        end else if (is_sep) begin
          phase_d = PH_HIGH;
        end else begin
          do_fail = 1'b1;
          fail_st = ST_BAD_CHAR;
        end
      end
      PH_DROP: begin
        if (is_end) begin
          phase_d = PH_HIGH;
          nib_d   = '0;
          count_d = '0;
        end
      end
    endcase

    // A byte past the capacity turns into an error
    if (do_emit && full) begin
      do_emit = 1'b0;
      do_fail = 1'b1;
      fail_st = ST_FULL;
    end

    res_valid_o        = do_emit || do_fail || do_finish;
    res_o.byte_valid   = do_emit;
    res_o.byte_value   = do_emit ? emit_val : 8'd0;
    res_o.text_done    = do_fail || do_finish || (do_emit && emit_done);
    res_o.parse_status = fail_st;
    res_o.bytes_so_far = do_emit ? count_inc : count_q;

    if (do_fail) begin
      phase_d = PH_DROP;
      nib_d   = '0;
      count_d = '0;
    end else if (do_finish || (do_emit && emit_done)) begin
      phase_d = PH_HIGH;
      nib_d   = '0;
      count_d = '0;
    end else if (do_emit) begin
      phase_d = emit_next;
      count_d = count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HIGH;
      nib_q   <= '0;
      count_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      nib_q   <= nib_d;
      count_q <= count_d;
    end
  end

  a_byte_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.byte_valid |-> res_o.parse_status == ST_OK)
    else $error("byte result carries an error status");

  a_error_ends_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.parse_status != ST_OK |-> res_o.text_done && !res_o.byte_valid)
    else $error("error result does not close the text");

  a_done_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && res_o.text_done |=> count_q == 16'd0)
    else $error("byte count not cleared after end of text");

  a_error_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && res_o.parse_status != ST_OK |=> phase_q == PH_DROP)
    else $error("parser not discarding after an error");

  a_drop_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DROP |-> !res_valid_o)
    else $error("result produced while discarding");

endmodule

@@ bench/tb_hex_byte_list_parser_top.sv @@
// Self-checking bench for hex_byte_list_parser_top: streams texts in, predicts each
// result with a scoreboard class and checks the result stream. Depends on hbl_pkg.
`timescale 1ns / 1ps

module tb_hex_byte_list_parser_top;
  import hbl_pkg::*;

  class hbl_scoreboard;
    typedef enum logic [1:0] {SCAN_HIGH, SCAN_LOW, SCAN_AFTER, SCAN_DROP} scan_e;

    logic [63:0] sep_lo, sep_hi, blank_lo, blank_hi;
    logic [15:0] capacity;
    scan_e       scan;
    logic [3:0]  nibble;
    logic [15:0] count;
    result_t     expected_q[$];
    int          errors;

    function new();
      sep_lo = '0;
      sep_hi = '0;
      blank_lo = '0;
      blank_hi = '0;
      capacity = CAP_RESET;
      scan = SCAN_HIGH;
      nibble = '0;
      count = '0;
      errors = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [63:0] v);
      case (idx)
        REG_SEP_LOW:    sep_lo = v;
        REG_SEP_HIGH:   sep_hi = v;
        REG_BLANK_LOW:  blank_lo = v;
        REG_BLANK_HIGH: blank_hi = v;
        REG_CAPACITY:   capacity = v[15:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] reg_value(reg_idx_e idx);
      case (idx)
        REG_SEP_LOW:    return sep_lo;
        REG_SEP_HIGH:   return sep_hi;
        REG_BLANK_LOW:  return blank_lo;
        REG_BLANK_HIGH: return blank_hi;
        default:        return {48'd0, capacity};
      endcase
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    static function logic char_in_set(logic [63:0] lo, logic [63:0] hi, logic [7:0] c);
      if (c >= 8'd128) return 1'b0;
      if (c >= 8'd64) return hi[c - 8'd64];
      return lo[c];
    endfunction

    static function logic [4:0] hex_digit(logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) d = c - CHAR_ZERO;
      else if (c >= CHAR_UC_A && c <= CHAR_UC_F) d = c - CHAR_UC_A + DIGIT_TEN;
      else if (c >= CHAR_LC_A && c <= CHAR_LC_F) d = c - CHAR_LC_A + DIGIT_TEN;
      else return HEX_NONE;
      return d[4:0];
    endfunction

    function string show(result_t r);
      return $sformatf("valid=%0b byte=%02h done=%0b status=%0d count=%0d",
                       r.byte_valid, r.byte_value, r.text_done, r.parse_status,
                       r.bytes_so_far);
    endfunction

    function void clear();
      scan = SCAN_HIGH;
      count = '0;
      nibble = '0;
    endfunction

    function void raise(status_e st);
      expected_q.push_back(result_t'{1'b0, 8'd0, 1'b1, st, count});
      scan = SCAN_DROP;
      count = '0;
      nibble = '0;
    endfunction

    function void push_byte(logic [7:0] val, logic done, scan_e nxt);
      if (count >= capacity) begin
        raise(ST_FULL);
        return;
      end
      count++;
      expected_q.push_back(result_t'{1'b1, val, done, ST_OK, count});
      if (done) clear();
      else scan = nxt;
    endfunction

    function void close_text();
      expected_q.push_back(result_t'{1'b0, 8'd0, 1'b1, ST_OK, count});
      clear();
    endfunction

    function void note_char(logic [7:0] c);
      logic       is_blank, is_sep;
      logic [4:0] dig;
      is_blank = char_in_set(blank_lo, blank_hi, c);
      is_sep = !is_blank && char_in_set(sep_lo, sep_hi, c);
      dig = hex_digit(c);
      case (scan)
        SCAN_HIGH: begin
          if (c == CHAR_END) close_text();
          else if (is_sep) push_byte(8'd0, 1'b0, SCAN_HIGH);
          else if (!is_blank) begin
            if (dig == HEX_NONE) raise(ST_BAD_DIGIT);
            else begin
              nibble = dig[3:0];
              scan = SCAN_LOW;
            end
          end
        end
        SCAN_LOW: begin
          if (c == CHAR_END) push_byte({4'd0, nibble}, 1'b1, SCAN_HIGH);
          else if (is_blank) push_byte({4'd0, nibble}, 1'b0, SCAN_AFTER);
          else if (is_sep) push_byte({4'd0, nibble}, 1'b0, SCAN_HIGH);
          else if (dig == HEX_NONE) raise(ST_BAD_DIGIT);
          else push_byte({nibble, dig[3:0]}, 1'b0, SCAN_AFTER);
        end
        SCAN_AFTER: begin
          if (c == CHAR_END) close_text();
          else if (is_sep) scan = SCAN_HIGH;
          else if (!is_blank) raise(ST_BAD_CHAR);
        end
        default: begin
          // drop everything up to the end of text
          if (c == CHAR_END) clear();
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected result: %s", show(got)));
        return;
      end
      want = expected_q.pop_front();
      if (got.byte_valid !== want.byte_valid || got.byte_value !== want.byte_value ||
          got.text_done !== want.text_done || got.parse_status !== want.parse_status ||
          got.bytes_so_far !== want.bytes_so_far)
        flag($sformatf("result mismatch: expected %s, got %s", show(want), show(got)));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] text_char
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [7:0] byte_value, [23:8] bytes_so_far
  logic [2:0]  m_axis_tuser;        // [0] byte_valid, [2:1] parse_status
  logic        m_axis_tlast;        // text_done

  hbl_scoreboard sb;
  result_t       seen;
  logic [7:0]    blank_set[$];
  logic [7:0]    sep_set[$];
  bit            rx_free = 1'b1;
  logic [15:0]   rx_pat = 16'hFFFF;
  logic [3:0]    rx_pos = '0;
  int            burst_left = 0;
  int            tx_gap_max = 0;
  int            noise_pct = 0;
  int            chars_sent = 0;

  hex_byte_list_parser_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver stalls follow a 16-bit pattern, bit 0 always set to bound a stall
  always @(posedge clk_i) begin
    if (rx_free) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= rx_pat[rx_pos];
      rx_pos = rx_pos + 4'd1;
      if (rx_pos == 4'd0) begin
        rx_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        rx_pat[0] = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_char(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        seen.byte_valid = m_axis_tuser[0];
        seen.byte_value = m_axis_tdata[7:0];
        seen.text_done = m_axis_tlast;
        seen.parse_status = status_e'(m_axis_tuser[2:1]);
        seen.bytes_so_far = m_axis_tdata[23:8];
        sb.check_result(seen);
      end
    end
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(1, 127));
    while (hbl_scoreboard::hex_digit(c) != HEX_NONE) c = 8'($urandom_range(1, 127));
    return c;
  endfunction

  function automatic logic [7:0] hex_char();
    logic [7:0] v;
    v = 8'($urandom_range(0, 15));
    if (v < DIGIT_TEN) return CHAR_ZERO + v;
    return ($urandom_range(0, 1) ? CHAR_UC_A : CHAR_LC_A) + v - DIGIT_TEN;
  endfunction

  function automatic logic [7:0] pick(ref logic [7:0] q[$]);
    return q[$urandom_range(0, q.size() - 1)];
  endfunction

  function automatic logic [127:0] map_of(ref logic [7:0] q[$]);
    logic [127:0] m;
    m = '0;
    foreach (q[i]) m[q[i][6:0]] = 1'b1;
    return m;
  endfunction

  task automatic send_char(input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = (tx_gap_max > 0) ? $urandom_range(1, tx_gap_max) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    chars_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(CHAR_END);
  endtask

  // Hold off until every predicted result has come back and the pipeline is empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, val);
    // read back through a second transfer without dropping psel
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== sb.reg_value(idx))
      sb.flag($sformatf("register %0d readback: expected %016h, got %016h",
                        idx, sb.reg_value(idx), prdata));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_config(input logic [127:0] sep_map, input logic [127:0] blank_map,
                              input logic [15:0] cap);
    reg_write(REG_SEP_LOW, sep_map[63:0]);
    reg_write(REG_SEP_HIGH, sep_map[127:64]);
    reg_write(REG_BLANK_LOW, blank_map[63:0]);
    reg_write(REG_BLANK_HIGH, blank_map[127:64]);
    reg_write(REG_CAPACITY, {48'd0, cap});
  endtask

  task automatic put_char(input logic [7:0] c);
    if ($urandom_range(0, 99) < noise_pct) c = 8'($urandom_range(1, 255));
    send_char(c);
  endtask

  task automatic maybe_blanks();
    if (blank_set.size() != 0)
      repeat ($urandom_range(0, 2)) put_char(pick(blank_set));
  endtask

  // Mostly well-formed list: fields of up to two digits, optional blanks around
  task automatic send_text();
    int groups;
    groups = (sep_set.size() == 0) ? 1 : $urandom_range(0, 6);
    for (int i = 0; i < groups; i++) begin
      if (i > 0) put_char(pick(sep_set));
      maybe_blanks();
      case ($urandom_range(0, 9))
        0: ;
        1, 2: put_char(hex_char());
        default: begin
          put_char(hex_char());
          put_char(hex_char());
        end
      endcase
      maybe_blanks();
    end
    if (sep_set.size() != 0 && $urandom_range(0, 9) == 0) put_char(pick(sep_set));
    send_char(CHAR_END);
  endtask

  task automatic run_phase(input int kind, input int n_chars);
    logic [127:0] sep_map, blank_map;
    logic [15:0]  cap;
    int           stop_at;
    drain();
    blank_set = '{" ", "\t"};
    sep_set = '{",", ":"};
    if (kind == 1 || kind == 5) begin
      blank_set.delete();
      sep_set.delete();
      repeat ($urandom_range(1, 3)) blank_set.push_back(plain_char());
      repeat ($urandom_range(1, 3)) sep_set.push_back(plain_char());
    end
    sep_map = map_of(sep_set);
    blank_map = map_of(blank_set);
    cap = CAP_RESET;
    noise_pct = 4;
    tx_gap_max = 6;
    rx_free = 1'b0;
    case (kind)
      0: begin
        tx_gap_max = 0;
        rx_free = 1'b1;
      end
      1: begin
        cap = 16'($urandom_range(1, 4));
        noise_pct = 8;
      end
      2: cap = 16'd0;
      3: begin
        sep_map = '1;
        blank_map = '1;
        noise_pct = 10;
      end
      4: begin
        sep_set.delete();
        blank_set.delete();
        sep_map = '0;
        blank_map = '0;
        cap = 16'd1;
      end
      default: begin
        sep_map |= {$urandom, $urandom, $urandom, $urandom};
        blank_map |= {$urandom, $urandom, $urandom, $urandom};
        cap = $urandom_range(0, 1) ? 16'($urandom_range(1, 8)) : 16'($urandom_range(0, 65535));
        tx_gap_max = 3;
      end
    endcase
    apply_config(sep_map, blank_map, cap);
    stop_at = chars_sent + n_chars;
    while (chars_sent < stop_at) send_text();
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: no blanks, no separators, full capacity
    send_str("5a");
    drain();

    // Capacity of two; 'x' and '.' sit in both maps and count as blanks
    blank_set = '{" ", "\t", ".", "~", "x"};
    sep_set = '{",", ":", ".", "_", "x"};
    apply_config(map_of(sep_set), map_of(blank_set), 16'd2);
    send_str("A");
    send_str("ff,\t,7 g");
    send_str("");
    send_char(8'h80);
    send_char(8'hFF);
    send_char(CHAR_END);
    send_str("123");
    send_str("x9~_G");

    for (int k = 0; k < 6; k++) run_phase(k, 290);
    drain();

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/hbl_pkg.sv
rtl/core/hbl_cfg_regs.sv
rtl/core/hbl_parse_core.sv
rtl/core/hex_byte_list_parser_top.sv
bench/tb_hex_byte_list_parser_top.sv
